>>> rtl/usbreq_pkg.sv
package usbreq_pkg;

  localparam int USBREQ_NUM_ENDPOINTS = 8;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [APB_ADDR_W-3:0] REG_ENDPOINT_ENABLE_MASK = '0;
  localparam logic [7:0] ENDPOINT_ENABLE_MASK_RESET = 8'h01;

  // Response kinds.
  localparam logic [1:0] KIND_STALL = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_FETCH = 2'd3;

  // Device states.
  localparam logic [1:0] ST_POWERED    = 2'd0;
  localparam logic [1:0] ST_DEFAULT    = 2'd1;
  localparam logic [1:0] ST_ADDRESSED  = 2'd2;
  localparam logic [1:0] ST_CONFIGURED = 2'd3;

  // Standard request codes.
  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

  // bmRequestType values that are accepted.
  localparam logic [7:0] TYPE_DTH_DEV = 8'h80;
  localparam logic [7:0] TYPE_DTH_IF  = 8'h81;
  localparam logic [7:0] TYPE_DTH_EP  = 8'h82;
  localparam logic [7:0] TYPE_HTD_DEV = 8'h00;
  localparam logic [7:0] TYPE_HTD_EP  = 8'h02;

  localparam logic [6:0] ADDR_MASK = 7'h7F;

  typedef struct packed {
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
  } usbreq_req_t;

  typedef struct packed {
    logic [1:0]  response_kind;
    logic [15:0] data_word;
    logic [1:0]  data_bytes;
    logic [15:0] descriptor_selector;
    logic        endpoint_reset_valid;
    logic [2:0]  endpoint_reset_index;
    logic [1:0]  device_state_out;
    logic [6:0]  device_address_out;
    logic        configuration_out;
  } usbreq_rsp_t;

  typedef struct packed {
    logic        valid;
    usbreq_req_t req;
  } usbreq_stage_t;

endpackage

>>> rtl/usb_standard_request_handler.sv
// Channel   Direction  Handshake              Beat
// req       in         req_valid / req_ready  usbreq_req_t setup packet
// rsp       out        rsp_valid / rsp_ready  usbreq_rsp_t response
// apb       in/out     psel, penable, pready  endpoint_enable_mask register
//
// Each request is held in the input register and then decoded into the result
// register; one request can be taken every cycle while responses are not
// stalled. Synchronous reset clears the device state, the halt bits and both
// stage valids. A stalled response holds the pipeline, and req_ready drops only
// when both registers are full and rsp_ready is low.
module usb_standard_request_handler #(
  parameter int NUM_ENDPOINTS = usbreq_pkg::USBREQ_NUM_ENDPOINTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  usbreq_pkg::usbreq_req_t           req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output usbreq_pkg::usbreq_rsp_t           rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [usbreq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [usbreq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [usbreq_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready
);
  import usbreq_pkg::*;

  usbreq_stage_t stage;
  usbreq_rsp_t   core_rsp;
  logic [7:0]    endpoint_enable_mask;
  logic          space;
  logic          fire;

  assign fire = stage.valid && space;

  usbreq_apb u_apb (
    .clk                  (clk),
    .rst                  (rst),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .endpoint_enable_mask (endpoint_enable_mask)
  );

  usbreq_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .advance   (fire),
    .stage     (stage)
  );

  usbreq_core #(
    .NUM_ENDPOINTS (NUM_ENDPOINTS)
  ) u_core (
    .clk                  (clk),
    .rst                  (rst),
    .fire                 (fire),
    .req                  (stage.req),
    .endpoint_enable_mask (endpoint_enable_mask),
    .rsp                  (core_rsp)
  );

  usbreq_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .rsp_in    (core_rsp),
    .space     (space),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

>>> rtl/usbreq_apb.sv
module usbreq_apb (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [usbreq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [usbreq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [usbreq_pkg::APB_DATA_W-1:0] prdata,
  output logic                              pready,
  output logic [7:0]                        endpoint_enable_mask
);
  import usbreq_pkg::*;

  logic reg_sel;

  assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_ENDPOINT_ENABLE_MASK);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(APB_DATA_W-8){1'b0}}, endpoint_enable_mask} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      endpoint_enable_mask <= ENDPOINT_ENABLE_MASK_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      endpoint_enable_mask <= pwdata[7:0];
    end
  end

endmodule

>>> rtl/usbreq_in_stage.sv
module usbreq_in_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  usbreq_pkg::usbreq_req_t   req,
  input  logic                      advance,
  output usbreq_pkg::usbreq_stage_t stage
);
  import usbreq_pkg::*;

  // The stage takes a new beat whenever it is empty or drains this cycle.
  assign req_ready = !stage.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (req_ready) begin
      stage.valid <= req_valid;
    end
    if (req_valid && req_ready) begin
      stage.req <= req;
    end
  end

endmodule

>>> rtl/usbreq_core.sv
module usbreq_core #(
  parameter int NUM_ENDPOINTS = usbreq_pkg::USBREQ_NUM_ENDPOINTS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  usbreq_pkg::usbreq_req_t req,
  input  logic [7:0]              endpoint_enable_mask,
  output usbreq_pkg::usbreq_rsp_t rsp
);
  import usbreq_pkg::*;

  localparam int EP_IDX_W = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;

  logic [1:0]               device_state, device_state_next;
  logic [6:0]               device_address, device_address_next;
  logic                     address_enabled, address_enabled_next;
  logic                     configuration_number, configuration_number_next;
  logic [NUM_ENDPOINTS-1:0] endpoint_halted, endpoint_halted_next;

  logic [3:0] ep;
  logic       ep_in_range;
  logic       ep_enabled;
  logic       halt_bit;

  assign ep          = req.request_index[3:0];
  assign ep_in_range = ({1'b0, ep} < 5'(NUM_ENDPOINTS));
  // Halt control only reaches the first eight endpoints of the enable mask.
  assign ep_enabled  = ep_in_range && !ep[3] && endpoint_enable_mask[ep[2:0]];
  assign halt_bit    = ep_in_range && endpoint_halted[ep[EP_IDX_W-1:0]];

  always_comb begin
    rsp                       = '0;
    rsp.response_kind         = KIND_STALL;
    device_state_next         = device_state;
    device_address_next       = device_address;
    address_enabled_next      = address_enabled;
    configuration_number_next = configuration_number;
    endpoint_halted_next      = endpoint_halted;

    case (req.request_code)
      REQ_GET_STATUS: begin
        if (req.request_type == TYPE_DTH_EP) begin
          rsp.data_word     = {15'd0, halt_bit};
          rsp.data_bytes    = 2'd2;
          rsp.response_kind = KIND_DATA;
        end
      end
      REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
        if (req.request_type == TYPE_HTD_EP) begin
          if (req.request_value[7:0] != 8'd0) begin
            rsp.response_kind = KIND_ACK;
          end else if (ep != 4'd0) begin
            rsp.response_kind = KIND_ACK;
            if (ep_enabled) begin
              for (int i = 0; i < NUM_ENDPOINTS; i++) begin
                if (ep == 4'(i)) begin
                  endpoint_halted_next[i] = (req.request_code == REQ_SET_FEATURE);
                end
              end
              if (req.request_code == REQ_CLEAR_FEATURE) begin
                rsp.endpoint_reset_valid = 1'b1;
                rsp.endpoint_reset_index = ep[2:0];
              end
            end
          end
        end
      end
      REQ_SET_ADDRESS: begin
        if (req.request_type == TYPE_HTD_DEV) begin
          device_address_next  = req.request_value[6:0] & ADDR_MASK;
          address_enabled_next = 1'b1;
          device_state_next    = (req.request_value[6:0] != 7'd0) ? ST_ADDRESSED
                                                                  : ST_DEFAULT;
          rsp.response_kind    = KIND_ACK;
        end
      end
      REQ_GET_DESCRIPTOR: begin
        if (req.request_type == TYPE_DTH_DEV || req.request_type == TYPE_DTH_IF) begin
          rsp.descriptor_selector = req.request_value;
          rsp.response_kind       = KIND_FETCH;
        end
      end
      REQ_GET_CONFIGURATION: begin
        if (req.request_type == TYPE_DTH_DEV) begin
          rsp.data_word     = {15'd0, configuration_number};
          rsp.data_bytes    = 2'd1;
          rsp.response_kind = KIND_DATA;
        end
      end
      REQ_SET_CONFIGURATION: begin
        if (req.request_type == TYPE_HTD_DEV && req.request_value[7:1] == 7'd0) begin
          configuration_number_next = req.request_value[0];
          if (req.request_value[0]) begin
            device_state_next = ST_CONFIGURED;
          end else begin
            device_state_next = address_enabled ? ST_ADDRESSED : ST_DEFAULT;
          end
          rsp.response_kind = KIND_ACK;
        end
      end
      default: begin
      end
    endcase

    rsp.device_state_out   = device_state_next;
    rsp.device_address_out = device_address_next;
    rsp.configuration_out  = configuration_number_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_state         <= ST_DEFAULT;
      device_address       <= '0;
      address_enabled      <= 1'b0;
      configuration_number <= 1'b0;
      endpoint_halted      <= '0;
    end else if (fire) begin
      device_state         <= device_state_next;
      device_address       <= device_address_next;
      address_enabled      <= address_enabled_next;
      configuration_number <= configuration_number_next;
      endpoint_halted      <= endpoint_halted_next;
    end
  end

endmodule

>>> rtl/usbreq_out_stage.sv
module usbreq_out_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  usbreq_pkg::usbreq_rsp_t rsp_in,
  output logic                    space,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output usbreq_pkg::usbreq_rsp_t rsp
);
  import usbreq_pkg::*;

  assign space = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (space) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= rsp_in;
    end
  end

endmodule

>>> rtl/usbreq_checker.sv
module usbreq_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input usbreq_pkg::usbreq_rsp_t rsp
);
  import usbreq_pkg::*;

  // A response beat that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response beat dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // Only IN data responses carry a byte count.
  a_data_bytes: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp.response_kind == KIND_DATA) == (rsp.data_bytes != 2'd0)))
    else $error("byte count does not match response kind");

  a_stall_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.response_kind == KIND_STALL |->
      rsp.data_word == 16'd0 && rsp.descriptor_selector == 16'd0 &&
      !rsp.endpoint_reset_valid)
    else $error("stalled request carries payload or endpoint reset");

  // The configured state can only be reached through configuration one.
  a_configured: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.device_state_out == ST_CONFIGURED |-> rsp.configuration_out)
    else $error("configured state without a configuration");

endmodule

bind usb_standard_request_handler usbreq_checker u_usbreq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

>>> verif/usb_standard_request_handler_test.sv
module usb_standard_request_handler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import usbreq_pkg::*;

  localparam int NUM_EP = USBREQ_NUM_ENDPOINTS;
  localparam int EP_IDX_W = (NUM_EP > 1) ? $clog2(NUM_EP) : 1;
  localparam time RUN_LIMIT = 2ms;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  usbreq_req_t           req = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  usbreq_rsp_t           rsp;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  usb_standard_request_handler uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Device model kept alongside the block.
  logic [1:0]        dev_state = ST_DEFAULT;
  logic [6:0]        dev_address = '0;
  logic              address_set = 1'b0;
  logic              config_num = 1'b0;
  logic [NUM_EP-1:0] ep_halted = '0;
  logic [7:0]        ep_enable_mask = ENDPOINT_ENABLE_MASK_RESET;

  usbreq_req_t setup_queue[$];
  usbreq_rsp_t expected_rsps[$];

  int error_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int reset_pulses = 0;
  int kinds_seen[4] = '{0, 0, 0, 0};
  int burst_left = 1;
  int gap_left = 0;
  int ready_mode = 0;
  int mode_left = 0;
  logic [7:0] cycle_cnt = '0;

  // Applies one setup packet to the device model and returns the response it calls for.
  function automatic usbreq_rsp_t apply_setup(usbreq_req_t s);
    usbreq_rsp_t r;
    logic [3:0] ep;
    logic [EP_IDX_W-1:0] ep_idx;
    r = '0;
    r.response_kind = KIND_STALL;
    ep = s.request_index[3:0];
    ep_idx = ep[EP_IDX_W-1:0];
    case (s.request_code)
      REQ_GET_STATUS: begin
        if (s.request_type == TYPE_DTH_EP) begin
          if (ep < NUM_EP) r.data_word[0] = ep_halted[ep_idx];
          r.data_bytes = 2'd2;
          r.response_kind = KIND_DATA;
        end
      end
      REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
        if (s.request_type == TYPE_HTD_DEV) begin
          r.response_kind = KIND_STALL;
        end else if (s.request_type == TYPE_HTD_EP) begin
          if (s.request_value[7:0] != 8'h00) begin
            r.response_kind = KIND_ACK;
          end else if (ep == 4'd0) begin
            r.response_kind = KIND_STALL;
          end else begin
            r.response_kind = KIND_ACK;
            if (ep < NUM_EP && ep < 8 && ep_enable_mask[ep[2:0]]) begin
              if (s.request_code == REQ_SET_FEATURE) begin
                ep_halted[ep_idx] = 1'b1;
              end else begin
                ep_halted[ep_idx] = 1'b0;
                r.endpoint_reset_valid = 1'b1;
                r.endpoint_reset_index = ep[2:0];
              end
            end
          end
        end
      end
      REQ_SET_ADDRESS: begin
        if (s.request_type == TYPE_HTD_DEV) begin
          dev_address = s.request_value[6:0] & ADDR_MASK;
          address_set = 1'b1;
          dev_state = (dev_address != '0) ? ST_ADDRESSED : ST_DEFAULT;
          r.response_kind = KIND_ACK;
        end
      end
      REQ_GET_DESCRIPTOR: begin
        if (s.request_type == TYPE_DTH_DEV || s.request_type == TYPE_DTH_IF) begin
          r.descriptor_selector = s.request_value;
          r.response_kind = KIND_FETCH;
        end
      end
      REQ_GET_CONFIGURATION: begin
        if (s.request_type == TYPE_DTH_DEV) begin
          r.data_word[0] = config_num;
          r.data_bytes = 2'd1;
          r.response_kind = KIND_DATA;
        end
      end
      REQ_SET_CONFIGURATION: begin
        if (s.request_type == TYPE_HTD_DEV && s.request_value[7:0] <= 8'd1) begin
          config_num = s.request_value[0];
          if (config_num) dev_state = ST_CONFIGURED;
          else dev_state = address_set ? ST_ADDRESSED : ST_DEFAULT;
          r.response_kind = KIND_ACK;
        end
      end
      default: ;
    endcase
    r.device_state_out = dev_state;
    r.device_address_out = dev_address;
    r.configuration_out = config_num;
    return r;
  endfunction

  function automatic void push_setup(logic [7:0] rtype, logic [7:0] code,
                                     logic [15:0] value, logic [15:0] index);
    usbreq_req_t s;
    s.request_type = rtype;
    s.request_code = code;
    s.request_value = value;
    s.request_index = index;
    setup_queue.push_back(s);
  endfunction

  // Mostly well-formed standard requests with random content, the rest noise.
  function automatic usbreq_req_t random_setup();
    usbreq_req_t s;
    int pick;
    s.request_type = 8'($urandom);
    s.request_code = 8'($urandom);
    s.request_value = 16'($urandom);
    s.request_index = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      s.request_type = TYPE_DTH_EP;
      s.request_code = REQ_GET_STATUS;
    end else if (pick < 40) begin
      s.request_type = ($urandom_range(0, 5) == 0) ? TYPE_HTD_DEV : TYPE_HTD_EP;
      s.request_code = $urandom_range(0, 1) ? REQ_SET_FEATURE : REQ_CLEAR_FEATURE;
      if ($urandom_range(0, 4) != 0) s.request_value[7:0] = 8'h00;
      if ($urandom_range(0, 1) != 0) s.request_index[15:4] = '0;
    end else if (pick < 50) begin
      s.request_type = TYPE_HTD_DEV;
      s.request_code = REQ_SET_ADDRESS;
      if ($urandom_range(0, 5) == 0) s.request_value[6:0] = '0;
    end else if (pick < 60) begin
      s.request_type = $urandom_range(0, 1) ? TYPE_DTH_DEV : TYPE_DTH_IF;
      s.request_code = REQ_GET_DESCRIPTOR;
    end else if (pick < 67) begin
      s.request_type = TYPE_DTH_DEV;
      s.request_code = REQ_GET_CONFIGURATION;
    end else if (pick < 80) begin
      s.request_type = TYPE_HTD_DEV;
      s.request_code = REQ_SET_CONFIGURATION;
      if ($urandom_range(0, 3) != 0) s.request_value[7:0] = 8'($urandom_range(0, 1));
    end else if (pick < 88) begin
      // A known request code under an arbitrary request type.
      case ($urandom_range(0, 6))
        0: s.request_code = REQ_GET_STATUS;
        1: s.request_code = REQ_CLEAR_FEATURE;
        2: s.request_code = REQ_SET_FEATURE;
        3: s.request_code = REQ_SET_ADDRESS;
        4: s.request_code = REQ_GET_DESCRIPTOR;
        5: s.request_code = REQ_GET_CONFIGURATION;
        default: s.request_code = REQ_SET_CONFIGURATION;
      endcase
    end
    return s;
  endfunction

  function automatic void load_random(int count);
    repeat (count) setup_queue.push_back(random_setup());
  endfunction

  function automatic void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endfunction

  task automatic wait_quiet();
    do @(negedge clk);
    while (setup_queue.size() != 0 || req_valid || expected_rsps.size() != 0);
  endtask

  task automatic write_enable_mask(logic [7:0] mask);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_ENDPOINT_ENABLE_MASK, 2'b00};
    pwdata <= {24'h0, mask};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    ep_enable_mask = mask;
  endtask

  // Setup packet driver: bursts of beats separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(apply_setup(req));
        accepted_count++;
      end
      if (!req_valid || req_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (setup_queue.size() != 0) begin
          req <= setup_queue.pop_front();
          req_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and back-pressure.
  always @(posedge clk) begin
    usbreq_rsp_t want;
    cycle_cnt <= cycle_cnt + 8'd1;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          error_count++;
          $display("%0t: response beat with nothing expected: expected none, actual %h",
                   $time, rsp);
        end else begin
          want = expected_rsps.pop_front();
          checked_count++;
          kinds_seen[rsp.response_kind]++;
          if (rsp.endpoint_reset_valid) reset_pulses++;
          compare_field("response_kind", 16'(want.response_kind),
                        16'(rsp.response_kind));
          compare_field("data_word", want.data_word, rsp.data_word);
          compare_field("data_bytes", 16'(want.data_bytes), 16'(rsp.data_bytes));
          compare_field("descriptor_selector", want.descriptor_selector,
                        rsp.descriptor_selector);
          compare_field("endpoint_reset_valid", 16'(want.endpoint_reset_valid),
                        16'(rsp.endpoint_reset_valid));
          compare_field("endpoint_reset_index", 16'(want.endpoint_reset_index),
                        16'(rsp.endpoint_reset_index));
          compare_field("device_state_out", 16'(want.device_state_out),
                        16'(rsp.device_state_out));
          compare_field("device_address_out", 16'(want.device_address_out),
                        16'(rsp.device_address_out));
          compare_field("configuration_out", 16'(want.configuration_out),
                        16'(rsp.configuration_out));
        end
      end
      if (mode_left > 0) begin
        mode_left--;
      end else begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      case (ready_mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= ($urandom_range(0, 9) < 7);
        2: rsp_ready <= (cycle_cnt[2:0] != 3'd0 && cycle_cnt[2:0] != 3'd3);
        default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset state, only endpoint 0 enabled.
    push_setup(TYPE_DTH_EP, REQ_GET_STATUS, 16'h0000, 16'h0001);
    push_setup(TYPE_DTH_DEV, REQ_GET_STATUS, 16'h0000, 16'h0000);
    push_setup(TYPE_HTD_DEV, REQ_SET_FEATURE, 16'h0000, 16'h0000);
    push_setup(TYPE_HTD_EP, REQ_SET_FEATURE, 16'h0000, 16'h0000);
    push_setup(TYPE_HTD_EP, REQ_SET_FEATURE, 16'h0000, 16'h0001);
    push_setup(TYPE_HTD_EP, REQ_SET_FEATURE, 16'h0001, 16'h0001);
    push_setup(TYPE_DTH_DEV, REQ_GET_CONFIGURATION, 16'h0000, 16'h0000);
    push_setup(TYPE_HTD_DEV, REQ_SET_CONFIGURATION, 16'h0000, 16'h0000);
    push_setup(TYPE_HTD_DEV, REQ_SET_CONFIGURATION, 16'h0001, 16'h0000);
    push_setup(TYPE_HTD_DEV, REQ_SET_CONFIGURATION, 16'h0002, 16'h0000);
    push_setup(TYPE_HTD_DEV, REQ_SET_ADDRESS, 16'h0000, 16'h0000);
    push_setup(TYPE_HTD_DEV, REQ_SET_CONFIGURATION, 16'h0000, 16'h0000);
    push_setup(TYPE_HTD_DEV, REQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF);
    push_setup(TYPE_DTH_DEV, REQ_GET_DESCRIPTOR, 16'hFFFF, 16'h0000);
    push_setup(TYPE_DTH_IF, REQ_GET_DESCRIPTOR, 16'h0000, 16'hFFFF);
    push_setup(TYPE_DTH_EP, REQ_GET_STATUS, 16'hFFFF, 16'hFFFF);
    push_setup(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    push_setup(TYPE_HTD_DEV, 8'h02, 16'h0000, 16'h0000);
    push_setup(TYPE_HTD_DEV, REQ_GET_CONFIGURATION, 16'h0000, 16'h0000);
    wait_quiet();

    write_enable_mask(8'hFF);
    push_setup(TYPE_HTD_EP, REQ_SET_FEATURE, 16'h0000, 16'h0087);
    push_setup(TYPE_DTH_EP, REQ_GET_STATUS, 16'h0000, 16'h0007);
    push_setup(TYPE_HTD_EP, REQ_CLEAR_FEATURE, 16'h0000, 16'h0007);
    push_setup(TYPE_DTH_EP, REQ_GET_STATUS, 16'h0000, 16'h0007);
    push_setup(TYPE_HTD_EP, REQ_SET_FEATURE, 16'h0000, 16'h000F);
    push_setup(TYPE_HTD_DEV, REQ_CLEAR_FEATURE, 16'h0000, 16'h0001);
    push_setup(8'h00, 8'h00, 16'h0000, 16'h0000);
    load_random(500);
    wait_quiet();

    write_enable_mask(8'h00);
    load_random(300);
    wait_quiet();

    write_enable_mask(8'($urandom));
    load_random(400);
    wait_quiet();

    write_enable_mask(ENDPOINT_ENABLE_MASK_RESET);
    load_random(300);
    wait_quiet();

    repeat (10) @(posedge clk);
    $display("Checked %0d of %0d setup packets: %0d stalls, %0d acks, %0d IN data, %0d fetches.",
             checked_count, accepted_count, kinds_seen[KIND_STALL], kinds_seen[KIND_ACK],
             kinds_seen[KIND_DATA], kinds_seen[KIND_FETCH]);
    $display("Enable masks all-on, all-off, random and reset value; %0d endpoint resets seen.",
             reset_pulses);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Timed out with %0d responses outstanding.", expected_rsps.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
